@@ hw/rtl/lz_token_stream_decompressor_macros.svh @@
// assertion macros for the decompressor checker
`ifndef LZ_TOKEN_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZ_TOKEN_STREAM_DECOMPRESSOR_MACROS_SVH
// implication checked every clock outside reset
`define LZTS_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication checked outside reset
`define LZTS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ hw/rtl/lzts_pkg.sv @@
package lzts_pkg;
  localparam int unsigned HistoryDepth = 65536;
  localparam int unsigned OutBytes = 8;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned MinCopy = 4;
  localparam int unsigned ProducedMax = 65536;
  localparam logic [0:0] RegDistOrder = 1'b0;
endpackage

@@ hw/rtl/lz_token_stream_decompressor.sv @@
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_ready   | in_byte, stream_start
// output  | out       | out_valid/out_ready | out_data, out_count, run_last,
//         |           |                     | stream_end, bad_distance
// config  | in        | apb psel/penable    | distance_byte_order at 0x0
// header, literal and token bytes are taken whenever the output register
// is free; a byte behind a waiting beat is held until that beat leaves.
// a copy of code+4 bytes handles each byte as a read issue, then a take and
// write back that waits for a free output register; input is held meanwhile.
// synchronous reset clears control state; history is not cleared.
// output stalls hold the copy engine and the input.
module lz_token_stream_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lzts_pkg::HistoryDepth,
  parameter int unsigned OUT_BYTES = lzts_pkg::OutBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        stream_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic [3:0]  out_count,
  output logic        run_last,
  output logic        stream_end,
  output logic        bad_distance,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned OBW = $clog2(OUT_BYTES + 1);

  typedef enum logic [2:0] {
    PH_HEADER, PH_LITERALS, PH_TOKEN, PH_DONE, PH_COPY
  } phase_t;

  phase_t      phase;
  logic [7:0]  pcnt;
  logic [15:0] tdist;
  logic [7:0]  tcode;
  logic [7:0]  next_lits;
  logic [AW-1:0] wptr;
  logic [16:0] produced;
  logic        dist_order;
  logic [8:0]  left;
  logic        rd_pend;
  logic [2:0]  bidx;
  logic [OBW-1:0] bcnt;
  logic [63:0] acc;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [7:0]    cbyte;

  lzts_ram #(.Width(8), .Depth(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // config port
  assign pready = 1'b1;
  assign prdata = {31'd0, dist_order};
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_order <= 1'b0;
    end else if (psel && penable && pwrite && paddr == lzts_pkg::RegDistOrder) begin
      dist_order <= pwdata[0];
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = out_free && phase != PH_COPY;
  logic acc_in;
  assign acc_in = in_valid && in_ready;

  // source for the copy byte follows the write pointer
  assign raddr = wptr - tdist[AW-1:0];
  // each read is issued in the cycle after the previous write back lands
  assign cbyte = rdata;

  logic [16:0] dist_ext;
  assign dist_ext = {1'b0, tdist};
  logic [AW:0] depth_w;
  assign depth_w = (AW+1)'(HISTORY_DEPTH);
  logic [7:0] lo_dist;
  assign lo_dist = 8'(tdist);

  logic copy_step;
  assign copy_step = phase == PH_COPY && rd_pend && out_free;

  // history write: literal bytes or copied bytes
  always_comb begin
    we = 1'b0;
    wdata = in_byte;
    waddr = wptr;
    if (acc_in && !stream_start && phase == PH_LITERALS) begin
      we = 1'b1;
    end else if (copy_step) begin
      we = 1'b1;
      wdata = cbyte;
    end
  end

  // decode sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      pcnt <= 8'd0;
      tdist <= 16'd0;
      tcode <= 8'd0;
      wptr <= '0;
      produced <= 17'd0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      logic out_valid_next;
      // beat leaves unless stalled; a new beat may load below
      out_valid_next = out_valid && !out_ready;
      if (we) begin
        wptr <= wptr + 1'b1;
        if (produced < 17'(lzts_pkg::ProducedMax)) produced <= produced + 1'b1;
      end else if (acc_in && stream_start) begin
        wptr <= '0;
        produced <= 17'd0;
      end
      if (acc_in) begin
        phase_t ph;
        ph = stream_start ? PH_HEADER : phase;
        case (ph)
          PH_HEADER: begin
            if ((stream_start ? 8'd0 : pcnt) == 8'(lzts_pkg::HeaderBytes - 1)) begin
              phase <= (in_byte != 8'd0) ? PH_LITERALS : PH_TOKEN;
              pcnt <= in_byte;
            end else begin
              phase <= PH_HEADER;
              pcnt <= (stream_start ? 8'd0 : pcnt) + 8'd1;
            end
          end
          PH_LITERALS: begin
            out_valid_next = 1'b1;
            out_data <= {56'd0, in_byte};
            out_count <= 4'd1;
            run_last <= 1'b1;
            stream_end <= 1'b0;
            bad_distance <= 1'b0;
            pcnt <= pcnt - 8'd1;
            if (pcnt == 8'd1) begin
              phase <= PH_TOKEN;
            end
          end
          PH_TOKEN: begin
            if (pcnt == 8'd0) begin
              tdist <= dist_order ? {in_byte, 8'd0} : {8'd0, in_byte};
              pcnt <= 8'd1;
            end else if (pcnt == 8'd1) begin
              tdist <= dist_order ? {tdist[15:8], in_byte} : {in_byte, lo_dist};
              pcnt <= 8'd2;
            end else if (pcnt == 8'd2) begin
              tcode <= in_byte;
              pcnt <= 8'd3;
            end else begin
              next_lits <= in_byte;
              if (tcode != 8'd0) begin
                if (tdist == 16'd0 || dist_ext > produced ||
                    17'(depth_w) < dist_ext) begin
                  out_valid_next = 1'b1;
                  out_data <= 64'd0;
                  out_count <= '0;
                  run_last <= 1'b1;
                  stream_end <= 1'b0;
                  bad_distance <= 1'b1;
                  phase <= (in_byte != 8'd0) ? PH_LITERALS : PH_TOKEN;
                  pcnt <= in_byte;
                end else begin
                  phase <= PH_COPY;
                  left <= 9'(tcode) + 9'(lzts_pkg::MinCopy);
                  rd_pend <= 1'b0;
                  bidx <= 3'd0;
                  bcnt <= '0;
                  acc <= 64'd0;
                end
              end else if (in_byte == 8'd0 && tdist == 16'd0) begin
                out_valid_next = 1'b1;
                out_data <= 64'd0;
                out_count <= '0;
                run_last <= 1'b1;
                stream_end <= 1'b1;
                bad_distance <= 1'b0;
                phase <= PH_DONE;
                pcnt <= 8'd0;
              end else begin
                phase <= (in_byte != 8'd0) ? PH_LITERALS : PH_TOKEN;
                pcnt <= in_byte;
              end
            end
          end
          default: begin
          end
        endcase
      end else if (phase == PH_COPY) begin
        // for each history byte: issue the read, then take it once the output is free
        if (!rd_pend) begin
          rd_pend <= 1'b1;
        end else if (out_free) begin
          logic [63:0] nacc;
          logic [OBW-1:0] nb;
          nacc = acc | (64'(cbyte) << {bidx, 3'b000});
          nb = bcnt + 1'b1;
          left <= left - 9'd1;
          rd_pend <= 1'b0;
          if (nb == OBW'(OUT_BYTES) || left == 9'd1) begin
            out_valid_next = 1'b1;
            out_data <= nacc;
            out_count <= 4'(nb);
            run_last <= left == 9'd1;
            stream_end <= 1'b0;
            bad_distance <= 1'b0;
            acc <= 64'd0;
            bidx <= 3'd0;
            bcnt <= '0;
          end else begin
            acc <= nacc;
            bidx <= bidx + 3'd1;
            bcnt <= nb;
          end
          if (left == 9'd1) begin
            phase <= (next_lits != 8'd0) ? PH_LITERALS : PH_TOKEN;
            pcnt <= next_lits;
          end
        end
      end
      out_valid <= out_valid_next;
    end
  end
endmodule

@@ hw/rtl/lzts_ram.sv @@
module lzts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/lzts_checker.sv @@
`include "lz_token_stream_decompressor_macros.svh"
module lzts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_count,
  input logic        stream_end,
  input logic        bad_distance,
  input logic [63:0] out_data
);
  `LZTS_ASSERT_IMP(a_count_max, clk, rst, out_valid, out_count <= 4'd8, "count above eight")
  `LZTS_ASSERT_IMP(a_flag_empty, clk, rst, out_valid && (stream_end || bad_distance), out_count == 4'd0 && out_data == 64'd0, "flag beat carries data")
  `LZTS_ASSERT_IMP(a_flags_excl, clk, rst, out_valid, !(stream_end && bad_distance), "both flags set")
  `LZTS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "beat dropped under stall")
  `LZTS_ASSERT_IMP(a_in_gate, clk, rst, in_valid && in_ready, !out_valid || out_ready, "taken while full")
endmodule

bind lz_token_stream_decompressor lzts_checker u_lzts_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_count(out_count),
  .stream_end(stream_end), .bad_distance(bad_distance), .out_data(out_data)
);

@@ tb/tb_lz_token_stream_decompressor.sv @@
`timescale 1ns / 100ps

module tb_lz_token_stream_decompressor;

  typedef enum logic [1:0] {PH_HEADER, PH_LITERALS, PH_TOKEN, PH_DONE} phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        fin;
    logic        bad;
  } out_beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        stream_start;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        run_last;
  logic        stream_end;
  logic        bad_distance;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lz_token_stream_decompressor dut (.*);

  // predictor state
  logic        order_hi_first;
  phase_t      phase;
  logic [7:0]  phase_cnt;
  logic [15:0] tok_dist;
  logic [7:0]  tok_code;
  logic [7:0]  history [lzts_pkg::HistoryDepth];
  logic [15:0] wr_ptr;
  int unsigned produced;

  in_beat_t  pending_bytes [$];
  out_beat_t expected_beats [$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_stall_pct;
  logic      hold_send;

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void record_byte(logic [7:0] b);
    history[wr_ptr] = b;
    wr_ptr = wr_ptr + 16'd1;
    if (produced < lzts_pkg::ProducedMax) produced++;
  endfunction

  function automatic void push_beat(logic [63:0] d, logic [3:0] c, logic f, logic b);
    out_beat_t r;
    r.data = d;
    r.count = c;
    r.last = 1'b0;
    r.fin = f;
    r.bad = b;
    expected_beats.push_back(r);
  endfunction

  function automatic void start_literals(logic [7:0] n);
    if (n != 0) begin
      phase = PH_LITERALS;
      phase_cnt = n;
    end else begin
      phase = PH_TOKEN;
      phase_cnt = 0;
    end
  endfunction

  // expected beats for one accepted stream byte
  function automatic void decode_byte(in_beat_t it);
    int beats_prior;
    int left;
    int n;
    logic [63:0] d;
    logic [7:0] v;
    beats_prior = expected_beats.size();
    if (it.start) begin
      phase = PH_HEADER;
      phase_cnt = 0;
      wr_ptr = 0;
      produced = 0;
    end
    case (phase)
      PH_HEADER: begin
        if (phase_cnt + 1 >= lzts_pkg::HeaderBytes) start_literals(it.data);
        else phase_cnt++;
      end
      PH_LITERALS: begin
        record_byte(it.data);
        push_beat({56'd0, it.data}, 4'd1, 1'b0, 1'b0);
        phase_cnt = phase_cnt - 8'd1;
        if (phase_cnt == 0) phase = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (phase_cnt == 0) begin
          tok_dist = order_hi_first ? {it.data, 8'd0} : {8'd0, it.data};
          phase_cnt = 1;
        end else if (phase_cnt == 1) begin
          if (order_hi_first) tok_dist[7:0] = it.data;
          else tok_dist[15:8] = it.data;
          phase_cnt = 2;
        end else if (phase_cnt == 2) begin
          tok_code = it.data;
          phase_cnt = 3;
        end else begin
          if (tok_code != 0) begin
            if (tok_dist == 0 || tok_dist > produced ||
                tok_dist > lzts_pkg::HistoryDepth) begin
              push_beat(64'd0, 4'd0, 1'b0, 1'b1);
            end else begin
              left = tok_code + lzts_pkg::MinCopy;
              while (left != 0) begin
                n = left < lzts_pkg::OutBytes ? left : lzts_pkg::OutBytes;
                d = 0;
                for (int i = 0; i < n; i++) begin
                  v = history[wr_ptr - tok_dist];
                  record_byte(v);
                  d[8*i +: 8] = v;
                end
                push_beat(d, n[3:0], 1'b0, 1'b0);
                left -= n;
              end
            end
          end
          if (it.data == 0 && tok_code == 0 && tok_dist == 0) begin
            push_beat(64'd0, 4'd0, 1'b1, 1'b0);
            phase = PH_DONE;
            phase_cnt = 0;
          end else begin
            start_literals(it.data);
          end
        end
      end
      default: ;
    endcase
    if (expected_beats.size() > beats_prior) expected_beats[$].last = 1'b1;
  endfunction

  // stream builders; gen_produced counts the bytes produced so far
  int unsigned gen_produced;

  task automatic add_byte(logic [7:0] b, logic s = 1'b0);
    pending_bytes.push_back('{data: b, start: s});
  endtask

  task automatic add_header(logic [7:0] lits);
    add_byte($urandom_range(0, 255), 1'b1);
    for (int i = 1; i < 15; i++) add_byte($urandom_range(0, 255));
    add_byte(lits);
    gen_produced = 0;
  endtask

  task automatic add_literals(int n);
    for (int i = 0; i < n; i++) add_byte($urandom_range(0, 255));
    gen_produced += n;
  endtask

  task automatic add_token(logic [15:0] dist_val, logic [7:0] code, logic [7:0] lits);
    if (order_hi_first) begin
      add_byte(dist_val[15:8]);
      add_byte(dist_val[7:0]);
    end else begin
      add_byte(dist_val[7:0]);
      add_byte(dist_val[15:8]);
    end
    add_byte(code);
    add_byte(lits);
    if (code != 0 && dist_val != 0 && dist_val <= gen_produced)
      gen_produced += code + lzts_pkg::MinCopy;
  endtask

  task automatic add_random_stream(int tokens);
    int lits;
    int code;
    int copy_dist;
    lits = $urandom_range(1, 6);
    add_header(lits);
    add_literals(lits);
    for (int t = 0; t < tokens; t++) begin
      lits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      code = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      copy_dist = $urandom_range(1, gen_produced);
      if ($urandom_range(0, 9) == 0)
        copy_dist = ($urandom_range(0, 1) == 0) ? 0 : gen_produced + 1;
      if (code == 0 && copy_dist == 0 && lits == 0) lits = 1;
      add_token(copy_dist[15:0], code[7:0], lits[7:0]);
      add_literals(lits);
    end
    add_token(16'd0, 8'd0, 8'd0);
    // now and then one to three ignored bytes after the end token
    if ($urandom_range(0, 1) == 1) add_literals($urandom_range(1, 3));
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // register write: setup then access
  task automatic write_order(logic v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= lzts_pkg::RegDistOrder;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    order_hi_first = v;
  endtask

  // sender; the byte on the port stays at the queue head until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte('{data: in_byte, start: stream_start});
        void'(pending_bytes.pop_front());
      end
      if ((!in_valid || in_ready) && pending_bytes.size() > 0
          && !hold_send && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_byte <= pending_bytes[0].data;
        stream_start <= pending_bytes[0].start;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
      if (out_valid && out_ready) begin
        got = '{data: out_data, count: out_count, last: run_last,
                fin: stream_end, bad: bad_distance};
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %h", got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat mismatch: data %h/%h count %0d/%0d last %b/%b end %b/%b bad %b/%b",
                       want.data, got.data, want.count, got.count, want.last, got.last,
                       want.fin, got.fin, want.bad, got.bad);
          end
        end
      end
    end
  end

  initial begin
    #10000000;
    $display("tb_lz_token_stream_decompressor: done, errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'd0;
    stream_start = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    order_hi_first = 1'b0;
    phase = PH_HEADER;
    phase_cnt = 0;
    tok_dist = 0;
    tok_code = 0;
    wr_ptr = 0;
    produced = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_send = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero literal count, bad distances, overlap, long copy
    write_order(1'b0);
    add_header(8'd3);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'hA5);
    gen_produced = 3;
    add_token(16'd1, 8'd0, 8'd0);   // no copy, no result
    add_token(16'd1, 8'd255, 8'd1); // overlapping long copy
    add_literals(1);
    add_token(16'd0, 8'd2, 8'd0);   // zero distance
    add_token(16'hFFFF, 8'd1, 8'd2); // beyond produced
    add_literals(2);
    add_token(16'd0, 8'd0, 8'd0);
    add_byte(8'h77);                // ignored after end
    wait_drained();

    write_order(1'b1);
    add_header(8'd0);
    gen_produced = 0;
    add_token(16'd1, 8'd3, 8'd4);   // copy with nothing produced
    add_literals(4);
    add_token(16'd4, 8'd4, 8'd0);
    add_token(16'd0, 8'd0, 8'd0);
    wait_drained();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 84 : 11) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 84 : 11) : 0;
      write_order(ph[0]);
      add_random_stream($urandom_range(1, 3));
      if (ph == 2) begin
        // sender holds off until everything so far has come out
        while (pending_bytes.size() > 8) @(posedge clk);
        hold_send = 1'b1;
        while (pending_bytes.size() != 0 && (in_valid || expected_beats.size() != 0))
          @(posedge clk);
        hold_send = 1'b0;
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("tb_lz_token_stream_decompressor: done, clean");
    end else begin
      $display("tb_lz_token_stream_decompressor: done, errors");
    end
    $finish;
  end

endmodule
